// ----- rtl/bsc_pkg.sv -----
// Shared types and constants for the barometric compensation pipeline.
// Used by every module under rtl/; depends on nothing else.
package bsc_pkg;

  // Fixed field widths
  localparam int unsigned RAW_W   = 20;
  localparam int unsigned TFINE_W = 27;  // fine temperature never exceeds 2^25 in magnitude
  localparam int unsigned DVS_W   = 31;  // |v1| <= 2^30 after the 33-bit shift
  localparam int unsigned OUT_W   = 32;

  // Pipeline depth of each section
  localparam int unsigned TEMP_STAGES = 4;
  localparam int unsigned COEF_STAGES = 6;
  localparam int unsigned DIV_STAGES  = 64;
  localparam int unsigned POST_STAGES = 6;
  localparam int unsigned LATENCY     = TEMP_STAGES + COEF_STAGES + DIV_STAGES + POST_STAGES;

  // Polynomial constants
  localparam logic signed [TFINE_W-1:0] TEMP_OFFSET = 27'sd128000;
  localparam logic [63:0] NUMER_SCALE  = 64'd3125;
  localparam logic signed [63:0] V1_BIAS = 64'sd140737488355328;  // 2^47

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMP       = 2'd0,
    CFG_PRESS_LO   = 2'd1,
    CFG_PRESS_HI   = 2'd2,
    CFG_PRESS_LAST = 2'd3
  } bsc_cfg_e;

  // Temperature section -> coefficient section
  typedef struct packed {
    logic signed [TFINE_W-1:0] tfine;
    logic [RAW_W-1:0]          raw_p;
  } bsc_tmp_t;

  // Fields that ride alongside the divider
  typedef struct packed {
    logic signed [TFINE_W-1:0] tfine;
    logic [DVS_W-1:0]          dvs;
    logic                      qneg;
    logic                      invalid;
  } bsc_side_t;

  // Coefficient section -> divider
  typedef struct packed {
    bsc_side_t   side;
    logic [63:0] dvd;
  } bsc_div_t;

  // Divider -> post section
  typedef struct packed {
    logic signed [TFINE_W-1:0] tfine;
    logic [63:0]               quot;
    logic                      qneg;
    logic                      invalid;
  } bsc_quo_t;

  // Final result beat
  typedef struct packed {
    logic signed [OUT_W-1:0] tfine;
    logic [OUT_W-1:0]        pressure;
    logic                    invalid;
  } bsc_res_t;

endpackage

// ----- rtl/bsc_temp.sv -----
// Temperature section: fine temperature from the raw reading, four stages.
// Depends on bsc_pkg.
module bsc_temp import bsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [RAW_W-1:0] raw_t_i,
  input  logic [RAW_W-1:0] raw_p_i,
  input  logic [47:0]      temp_cal_i,
  output logic             valid_o,
  output bsc_tmp_t         data_o
);

  localparam logic signed [60:0] RND_BIAS = (61'sd1 <<< 34) - 61'sd1;

  logic [15:0]        t1;
  logic signed [15:0] t2;
  logic signed [15:0] t3;
  assign t1 = temp_cal_i[15:0];
  assign t2 = $signed(temp_cal_i[31:16]);
  assign t3 = $signed(temp_cal_i[47:32]);

  logic [TEMP_STAGES-1:0] vld_q;
  logic [RAW_W-1:0]       rp1_q, rp2_q, rp3_q, rp4_q;

  // stage 1: offset against T1
  logic signed [21:0] d_d, d_q;
  assign d_d = $signed({2'b00, raw_t_i}) - $signed({2'b00, t1, 4'b0000});

  // stage 2: linear and square terms
  logic signed [37:0] dt2_d, dt2_q;
  logic signed [43:0] dd_d, dd_q;
  assign dt2_d = d_q * t2;
  assign dd_d  = d_q * d_q;

  // stage 3: full numerator
  logic signed [60:0] lin_x, num_d, num_q;
  assign lin_x = dt2_q;
  assign num_d = (lin_x <<< 20) + dd_q * t3;

  // stage 4: divide by 2^34 toward zero
  logic signed [60:0]        num_r;
  logic signed [TFINE_W-1:0] tf_d, tf_q;
  assign num_r = num_q + (num_q[60] ? RND_BIAS : 61'sd0);
  assign tf_d  = $signed(num_r[60:34]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TEMP_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    rp1_q <= raw_p_i;
    dt2_q <= dt2_d;
    dd_q  <= dd_d;
    rp2_q <= rp1_q;
    num_q <= num_d;
    rp3_q <= rp2_q;
    tf_q  <= tf_d;
    rp4_q <= rp3_q;
  end

  assign valid_o      = vld_q[TEMP_STAGES-1];
  assign data_o.tfine = tf_q;
  assign data_o.raw_p = rp4_q;

endmodule

// ----- rtl/bsc_coef.sv -----
// Coefficient section: v1/v2 pressure terms, numerator and sign split, six stages.
// Depends on bsc_pkg.
module bsc_coef import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  bsc_tmp_t    data_i,
  input  logic [63:0] press_lo_i,
  input  logic [63:0] press_hi_i,
  output logic        valid_o,
  output bsc_div_t    data_o
);

  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6;
  assign p1 = press_lo_i[15:0];
  assign p2 = $signed(press_lo_i[31:16]);
  assign p3 = $signed(press_lo_i[47:32]);
  assign p4 = $signed(press_lo_i[63:48]);
  assign p5 = $signed(press_hi_i[15:0]);
  assign p6 = $signed(press_hi_i[31:16]);

  logic [COEF_STAGES-1:0]    vld_q;
  logic signed [TFINE_W-1:0] tf1_q, tf2_q, tf3_q, tf4_q, tf5_q;
  logic [RAW_W-1:0]          rp1_q, rp2_q, rp3_q;

  // stage 1: temperature offset
  logic signed [TFINE_W-1:0] e_d, e_q;
  assign e_d = data_i.tfine - TEMP_OFFSET;

  // stage 2: first products
  logic signed [53:0] ee_d, ee_q;
  logic signed [42:0] ep5_d, ep5_q, ep2_d, ep2_q;
  assign ee_d  = e_q * e_q;
  assign ep5_d = e_q * p5;
  assign ep2_d = e_q * p2;

  // stage 3: v2 and pre-scale v1, modulo 2^64
  logic signed [63:0] eep6, eep3, ep5_x, ep2_x, p4_x;
  logic signed [63:0] v2_d, v2_q, v1a_d, v1a_q;
  assign eep6  = ee_q * p6;
  assign eep3  = ee_q * p3;
  assign ep5_x = ep5_q;
  assign ep2_x = ep2_q;
  assign p4_x  = p4;
  assign v2_d  = eep6 + (ep5_x <<< 17) + (p4_x <<< 35);
  assign v1a_d = (eep3 >>> 8) + (ep2_x <<< 12);

  // stage 4: P1 scaling split in two halves; numerator base
  logic [63:0] bx;
  logic [47:0] mlo_d, mlo_q, mhi_full;
  logic [31:0] mhi_d, mhi_q;
  logic [20:0] p0;
  logic [63:0] n0_d, n0_q;
  assign bx       = v1a_q + V1_BIAS;
  assign mlo_d    = bx[31:0] * p1;
  assign mhi_full = bx[63:32] * p1;
  assign mhi_d    = mhi_full[31:0];
  assign p0       = 21'h100000 - {1'b0, rp3_q};
  assign n0_d     = {12'b0, p0, 31'b0} - v2_q;

  // stage 5: v1 and scaled numerator
  logic [63:0]            prod;
  logic signed [DVS_W-1:0] v1_d, v1_q;
  logic [63:0]            num_d, num_q;
  assign prod  = {16'b0, mlo_q} + {mhi_q, 32'b0};
  assign v1_d  = $signed(prod[63:33]);
  assign num_d = n0_q * NUMER_SCALE;

  // stage 6: magnitudes, quotient sign and zero-divisor flag
  bsc_div_t out_d, out_q;
  always_comb begin
    out_d.side.tfine   = tf5_q;
    out_d.side.invalid = (v1_q == '0);
    out_d.side.qneg    = num_q[63] ^ v1_q[DVS_W-1];
    out_d.side.dvs     = v1_q[DVS_W-1] ? (~v1_q + 1'b1) : v1_q;
    out_d.dvd          = num_q[63] ? (~num_q + 64'd1) : num_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[COEF_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    tf1_q <= data_i.tfine;
    rp1_q <= data_i.raw_p;
    ee_q  <= ee_d;
    ep5_q <= ep5_d;
    ep2_q <= ep2_d;
    tf2_q <= tf1_q;
    rp2_q <= rp1_q;
    v2_q  <= v2_d;
    v1a_q <= v1a_d;
    tf3_q <= tf2_q;
    rp3_q <= rp2_q;
    mlo_q <= mlo_d;
    mhi_q <= mhi_d;
    n0_q  <= n0_d;
    tf4_q <= tf3_q;
    v1_q  <= v1_d;
    num_q <= num_d;
    tf5_q <= tf4_q;
    out_q <= out_d;
  end

  assign valid_o = vld_q[COEF_STAGES-1];
  assign data_o  = out_q;

endmodule

// ----- rtl/bsc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Depends on bsc_pkg.
module bsc_div import bsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  bsc_div_t data_i,
  output logic     valid_o,
  output bsc_quo_t data_o
);

  logic [DIV_STAGES-1:0] vld_q;
  logic [63:0]           dq_q   [DIV_STAGES];
  logic [DVS_W-1:0]      rem_q  [DIV_STAGES];
  bsc_side_t             side_q [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic             vld_in;
    logic [63:0]      dq_in;
    logic [DVS_W-1:0] rem_in;
    bsc_side_t        side_in;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   dvs_x;
    logic [DVS_W:0]   diff;
    logic             take;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign dq_in   = data_i.dvd;
      assign rem_in  = '0;
      assign side_in = data_i.side;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign dq_in   = dq_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign side_in = side_q[i-1];
    end

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_in, dq_in[63]};
    assign dvs_x = {1'b0, side_in.dvs};
    assign diff  = trial - dvs_x;
    assign take  = (trial >= dvs_x);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dq_q[i]   <= {dq_in[62:0], take};
      rem_q[i]  <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      side_q[i] <= side_in;
    end
  end

  assign valid_o        = vld_q[DIV_STAGES-1];
  assign data_o.tfine   = side_q[DIV_STAGES-1].tfine;
  assign data_o.quot    = dq_q[DIV_STAGES-1];
  assign data_o.qneg    = side_q[DIV_STAGES-1].qneg;
  assign data_o.invalid = side_q[DIV_STAGES-1].invalid;

endmodule

// ----- rtl/bsc_post.sv -----
// Post-divide section: P7..P9 corrections and saturation to Q24.8, six stages.
// Depends on bsc_pkg.
module bsc_post import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  bsc_quo_t    data_i,
  input  logic [63:0] press_hi_i,
  input  logic [15:0] press_last_i,
  output logic        valid_o,
  output bsc_res_t    data_o
);

  logic signed [15:0] p7, p8, p9;
  assign p7 = $signed(press_hi_i[47:32]);
  assign p8 = $signed(press_hi_i[63:48]);
  assign p9 = $signed(press_last_i);

  logic [POST_STAGES-1:0]    vld_q;
  logic signed [TFINE_W-1:0] tf1_q, tf2_q, tf3_q, tf4_q, tf5_q;
  logic                      inv1_q, inv2_q, inv3_q, inv4_q, inv5_q;

  // stage 1: signed quotient
  logic [63:0] p_d, p1_q, p2_q, p3_q, p4_q;
  assign p_d = data_i.qneg ? (~data_i.quot + 64'd1) : data_i.quot;

  // stage 2: square halves and P8 halves
  logic signed [63:0] ps;
  logic [63:0]        sqll_d, sqll_q, sqhl_full;
  logic [31:0]        sqhl_d, sqhl_q;
  logic signed [48:0] m8lo_d, m8lo_q;
  logic signed [63:0] m8hi_full;
  logic [31:0]        m8hi_d, m8hi_q;
  assign ps        = $signed(p1_q) >>> 13;
  assign sqll_d    = ps[31:0] * ps[31:0];
  assign sqhl_full = ps[63:32] * ps[31:0];
  assign sqhl_d    = sqhl_full[31:0];
  assign m8lo_d    = $signed({1'b0, p1_q[31:0]}) * p8;
  assign m8hi_full = $signed(p1_q[63:32]) * p8;
  assign m8hi_d    = m8hi_full[31:0];

  // stage 3: square modulo 2^64, P8 term
  logic [63:0]        sq_d, sq_q;
  logic signed [63:0] m8lo_x, m8;
  logic [63:0]        w2_d, w2_q, w2b_q;
  assign sq_d   = sqll_q + {sqhl_q[30:0], 33'b0};
  assign m8lo_x = m8lo_q;
  assign m8     = m8lo_x + $signed({m8hi_q, 32'b0});
  assign w2_d   = m8 >>> 19;

  // stage 4: P9 halves
  logic signed [48:0] m9lo_d, m9lo_q;
  logic signed [63:0] m9hi_full;
  logic [31:0]        m9hi_d, m9hi_q;
  assign m9lo_d    = $signed({1'b0, sq_q[31:0]}) * p9;
  assign m9hi_full = $signed(sq_q[63:32]) * p9;
  assign m9hi_d    = m9hi_full[31:0];

  // stage 5: sum of corrections
  logic signed [63:0] m9lo_x, m9, w1;
  logic [63:0]        s_d, s_q;
  assign m9lo_x = m9lo_q;
  assign m9     = m9lo_x + $signed({m9hi_q, 32'b0});
  assign w1     = m9 >>> 25;
  assign s_d    = p4_q + w1 + w2b_q;

  // stage 6: final offset and saturation
  logic signed [63:0] p7_x, fin;
  bsc_res_t           res_d, res_q;
  assign p7_x = p7;
  assign fin  = ($signed(s_q) >>> 8) + (p7_x <<< 4);
  always_comb begin
    res_d.tfine   = tf5_q;
    res_d.invalid = inv5_q;
    if (inv5_q || fin[63]) begin
      res_d.pressure = '0;
    end else if (|fin[62:32]) begin
      res_d.pressure = '1;
    end else begin
      res_d.pressure = fin[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[POST_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= p_d;
    tf1_q  <= data_i.tfine;
    inv1_q <= data_i.invalid;
    sqll_q <= sqll_d;
    sqhl_q <= sqhl_d;
    m8lo_q <= m8lo_d;
    m8hi_q <= m8hi_d;
    p2_q   <= p1_q;
    tf2_q  <= tf1_q;
    inv2_q <= inv1_q;
    sq_q   <= sq_d;
    w2_q   <= w2_d;
    p3_q   <= p2_q;
    tf3_q  <= tf2_q;
    inv3_q <= inv2_q;
    m9lo_q <= m9lo_d;
    m9hi_q <= m9hi_d;
    w2b_q  <= w2_q;
    p4_q   <= p3_q;
    tf4_q  <= tf3_q;
    inv4_q <= inv3_q;
    s_q    <= s_d;
    tf5_q  <= tf4_q;
    inv5_q <= inv4_q;
    res_q  <= res_d;
  end

  assign valid_o = vld_q[POST_STAGES-1];
  assign data_o  = res_q;

endmodule

// ----- rtl/barometric_sensor_compensation.sv -----
// Barometric compensation top level: calibration registers and the pipeline.
// Depends on bsc_pkg, bsc_temp, bsc_coef, bsc_div and bsc_post.
//
// Usage:
//   Input: raise start with raw_temperature_i / raw_pressure_i; the pair is
//   taken on any rising edge with start high and busy low. busy stays low, so
//   a new sample pair may enter on every cycle.
//   Output: result_valid_o pulses for one cycle with fine_temperature_o,
//   pressure_q24_8_o (Pa, Q24.8, saturated) and pressure_invalid_o (zero
//   divisor, pressure forced to 0). The receiver has no way to stall.
//   The pipeline has 4 temperature stages, 6 coefficient stages, 64 divider
//   stages (one quotient bit each) and 6 post-divide stages. Throughput is
//   one sample pair per cycle.
//   Calibration: cfg_valid_i with cfg_index_i / cfg_data_i writes one
//   register per beat; cfg_ready_o is always high. Write only when no sample
//   is in flight.
//   Reset: rst_ni clears the calibration registers and all stage valid bits;
//   in-flight samples are dropped.
module barometric_sensor_compensation import bsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [RAW_W-1:0] raw_temperature_i,
  input  logic [RAW_W-1:0] raw_pressure_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i,
  output logic             result_valid_o,
  output logic [OUT_W-1:0] fine_temperature_o,
  output logic [OUT_W-1:0] pressure_q24_8_o,
  output logic             pressure_invalid_o
);

  logic [47:0] temp_cal_q;
  logic [63:0] press_lo_q;
  logic [63:0] press_hi_q;
  logic [15:0] press_last_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // calibration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q   <= '0;
      press_lo_q   <= '0;
      press_hi_q   <= '0;
      press_last_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TEMP:       temp_cal_q   <= cfg_data_i[47:0];
        CFG_PRESS_LO:   press_lo_q   <= cfg_data_i;
        CFG_PRESS_HI:   press_hi_q   <= cfg_data_i;
        CFG_PRESS_LAST: press_last_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic     in_beat;
  logic     tmp_vld, coef_vld, div_vld, post_vld;
  bsc_tmp_t tmp_data;
  bsc_div_t coef_data;
  bsc_quo_t div_data;
  bsc_res_t post_data;

  assign in_beat = start && !busy;

  bsc_temp u_temp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_beat),
    .raw_t_i    (raw_temperature_i),
    .raw_p_i    (raw_pressure_i),
    .temp_cal_i (temp_cal_q),
    .valid_o    (tmp_vld),
    .data_o     (tmp_data)
  );

  bsc_coef u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (tmp_vld),
    .data_i     (tmp_data),
    .press_lo_i (press_lo_q),
    .press_hi_i (press_hi_q),
    .valid_o    (coef_vld),
    .data_o     (coef_data)
  );

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (coef_vld),
    .data_i  (coef_data),
    .valid_o (div_vld),
    .data_o  (div_data)
  );

  bsc_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (div_vld),
    .data_i       (div_data),
    .press_hi_i   (press_hi_q),
    .press_last_i (press_last_q),
    .valid_o      (post_vld),
    .data_o       (post_data)
  );

  assign result_valid_o     = post_vld;
  assign fine_temperature_o = post_data.tfine;
  assign pressure_q24_8_o   = post_data.pressure;
  assign pressure_invalid_o = post_data.invalid;

`ifndef NO_ASSERTIONS
  // a result beat only ever follows an accepted sample that has passed through every stage of the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, LATENCY))
    else $error("result beat without a matching input beat");

  // zero divisor forces pressure to zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && pressure_invalid_o) |-> (pressure_q24_8_o == '0))
    else $error("invalid pressure not forced to zero");

  // temperature calibration write lands on the next cycle
  a_cfg_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_TEMP))
      |=> (temp_cal_q == $past(cfg_data_i[47:0])))
    else $error("temperature calibration write lost");
`endif

endmodule
